[rtl/mp3s2_pkg.sv]
// ----------------------------------------------------------------------------
// mp3s2_pkg
// Shared types, constants and float compare for the 3x3 stride-2 max pool.
// ----------------------------------------------------------------------------
package mp3s2_pkg;

  localparam int unsigned MAX_WIDTH = 4096;
  localparam int unsigned SampleW   = 32;
  localparam int unsigned CfgWidthW = 13;
  localparam int unsigned CfgHeightW = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned RowW      = 16;

  localparam logic [CfgIdxW-1:0] RegImageWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 2'd1;

  // Position flags of one sample, taken at accept time
  typedef struct packed {
    logic first_col;
    logic odd_col;
    logic last_col;
    logic hdone;
    logic row0;
    logic odd_row;
    logic last_row;
  } pos_t;

  function automatic logic is_nan(input logic [SampleW-1:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  // a > b in IEEE single ordering; NaN never compares greater
  function automatic logic fp_gt(input logic [SampleW-1:0] a, input logic [SampleW-1:0] b);
    logic res;
    res = 1'b0;
    if (is_nan(a) || is_nan(b)) begin
      res = 1'b0;
    end else if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
      res = 1'b0;
    end else if (a[31] != b[31]) begin
      res = b[31];
    end else if (!a[31]) begin
      res = a[30:0] > b[30:0];
    end else begin
      res = a[30:0] < b[30:0];
    end
    return res;
  endfunction

  // older kept on ties
  function automatic logic [SampleW-1:0] keep_max(input logic [SampleW-1:0] older,
                                                  input logic [SampleW-1:0] newer);
    return fp_gt(newer, older) ? newer : older;
  endfunction

endpackage

[rtl/mp3s2_if.sv]
// ----------------------------------------------------------------------------
// mp3s2 channel interfaces
// Sample input, pooled output and configuration write channels.
// ----------------------------------------------------------------------------
interface mp3s2_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mp3s2_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pooled;
  logic        last;
  modport source (output valid, output pooled, output last, input ready);
  modport sink   (input valid, input pooled, input last, output ready);
endinterface

interface mp3s2_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/mp3s2_seq.sv]
// ----------------------------------------------------------------------------
// mp3s2_seq
// Configuration registers and column/row position counters.
// ----------------------------------------------------------------------------
module mp3s2_seq #(
  parameter int unsigned MaxWidth = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [15:0]                 cfg_data_i,
  input  logic                        accept_i,
  output mp3s2_pkg::pos_t             pos_o,
  output logic [((MaxWidth > 2) ? $clog2(MaxWidth) - 1 : 1)-1:0] col_idx_o
);
  import mp3s2_pkg::*;

  localparam int unsigned XW = (MaxWidth > 2) ? $clog2(MaxWidth) : 1;
  localparam int unsigned CW = (MaxWidth > 2) ? XW - 1 : 1;
  localparam int unsigned EW = (XW + 1 > CfgWidthW) ? XW + 1 : CfgWidthW;

  logic [CfgWidthW-1:0]  width_q;
  logic [CfgHeightW-1:0] height_q;
  logic [XW-1:0]         x_q, x_d;
  logic [RowW-1:0]       y_q, y_d;
  logic [EW-1:0]         w_eff;
  logic [RowW-1:0]       h_eff;
  logic                  x_end, y_end;

  always_comb begin
    if (EW'(width_q) < EW'(2)) begin
      w_eff = EW'(2);
    end else if (EW'(width_q) > EW'(MaxWidth)) begin
      w_eff = EW'(MaxWidth);
    end else begin
      w_eff = EW'(width_q);
    end
    h_eff = (height_q < RowW'(2)) ? RowW'(2) : height_q;
  end

  assign x_end = (EW'(x_q) + EW'(1)) == w_eff;
  assign y_end = ({1'b0, y_q} + 17'd1) == {1'b0, h_eff};

  always_comb begin
    pos_o.first_col = (x_q == '0);
    pos_o.odd_col   = x_q[0];
    pos_o.last_col  = x_end;
    pos_o.hdone     = (x_q != '0) && (!x_q[0] || x_end);
    pos_o.row0      = (y_q == '0);
    pos_o.odd_row   = y_q[0];
    pos_o.last_row  = y_end;
  end

  // column pair index; same for odd x and the even x that follows it
  assign col_idx_o = CW'((x_q - XW'(1)) >> 1);

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (accept_i) begin
      if (x_end) begin
        x_d = '0;
        y_d = y_end ? '0 : y_q + RowW'(1);
      end else begin
        x_d = x_q + XW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgWidthW'(2);
      height_q <= CfgHeightW'(2);
      x_q      <= '0;
      y_q      <= '0;
    end else if (cfg_we_i && (cfg_idx_i == RegImageWidth || cfg_idx_i == RegImageHeight)) begin
      if (cfg_idx_i == RegImageWidth) begin
        width_q <= cfg_data_i[CfgWidthW-1:0];
      end else begin
        height_q <= cfg_data_i;
      end
      x_q <= '0;
      y_q <= '0;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

endmodule

[rtl/mp3s2_lbuf.sv]
// ----------------------------------------------------------------------------
// mp3s2_lbuf
// Line of partial column maxima: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mp3s2_lbuf #(
  parameter int unsigned Depth = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [31:0]   rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [31:0]   wr_data_i
);
  logic [31:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

[rtl/mp3s2_core.sv]
// ----------------------------------------------------------------------------
// mp3s2_core
// Sample register, horizontal/vertical max update and output register.
// ----------------------------------------------------------------------------
module mp3s2_core #(
  parameter int unsigned AW = 11
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clr_i,
  input  logic            accept_i,
  input  logic [31:0]     sample_i,
  input  mp3s2_pkg::pos_t pos_i,
  input  logic [AW-1:0]   col_idx_i,
  input  logic [31:0]     rd_data_i,
  output logic            wr_en_o,
  output logic [AW-1:0]   wr_addr_o,
  output logic [31:0]     wr_data_o,
  output logic            busy_o,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output logic [31:0]     out_pooled_o,
  output logic            out_last_o,
  input  logic            out_ready_i
);
  import mp3s2_pkg::*;

  logic               b_valid_q;
  logic [SampleW-1:0] s_q;
  pos_t               pos_q;
  logic [AW-1:0]      c_q;
  logic [SampleW-1:0] hmax_q, hmax_d;
  logic               fw_valid_q;
  logic [AW-1:0]      fw_addr_q;
  logic [SampleW-1:0] fw_data_q;
  logic               ov_q;
  logic [SampleW-1:0] opool_q;
  logic               olast_q;
  logic               b_fire;
  logic [SampleW-1:0] hval, line_old, vmax, wdata;
  logic               emit, emit_last;

  assign b_fire     = b_valid_q && (!ov_q || out_ready_i);
  assign in_ready_o = !b_valid_q || b_fire;
  assign busy_o     = b_valid_q || ov_q;

  // the previous write can land after this word's read was issued
  assign line_old = (fw_valid_q && fw_addr_q == c_q) ? fw_data_q : rd_data_i;

  always_comb begin
    hval = keep_max(hmax_q, s_q);
    if (pos_q.first_col) begin
      hmax_d = s_q;
    end else if (pos_q.odd_col) begin
      hmax_d = hval;
    end else begin
      hmax_d = s_q;
    end
    vmax      = keep_max(line_old, hval);
    emit      = 1'b0;
    emit_last = 1'b0;
    wdata     = hval;
    if (pos_q.row0) begin
      wdata = hval;
    end else if (pos_q.odd_row) begin
      wdata     = vmax;
      emit      = pos_q.last_row;
      emit_last = pos_q.last_col;
    end else begin
      wdata     = hval;
      emit      = 1'b1;
      emit_last = pos_q.last_col && pos_q.last_row;
    end
    emit = emit && pos_q.hdone;
  end

  assign wr_en_o   = b_fire && pos_q.hdone;
  assign wr_addr_o = c_q;
  assign wr_data_o = wdata;

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s_q   <= sample_i;
      pos_q <= pos_i;
      c_q   <= col_idx_i;
    end
    if (wr_en_o) begin
      fw_addr_q <= c_q;
      fw_data_q <= wdata;
    end
    if (b_fire && emit) begin
      opool_q <= vmax;
      olast_q <= emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q  <= 1'b0;
      ov_q       <= 1'b0;
      fw_valid_q <= 1'b0;
      hmax_q     <= '0;
    end else begin
      if (in_ready_o) begin
        b_valid_q <= accept_i;
      end
      if (b_fire) begin
        ov_q <= emit;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      if (wr_en_o) begin
        fw_valid_q <= 1'b1;
      end
      if (clr_i) begin
        hmax_q <= '0;
      end else if (b_fire) begin
        hmax_q <= hmax_d;
      end
    end
  end

  assign out_valid_o  = ov_q;
  assign out_pooled_o = opool_q;
  assign out_last_o   = olast_q;

endmodule

[rtl/max_pool_3x3_stride2.sv]
// ----------------------------------------------------------------------------
// max_pool_3x3_stride2
// 3x3 max pooling, stride 2, over a raster stream of float32 samples.
// ----------------------------------------------------------------------------
// Channels: in_i takes one sample word per accepted valid/ready beat, in
// raster order. out_o gives one pooled word when the last sample of a
// clipped 3x3 window arrives; last marks the final word of the image.
// cfg_i writes image_width (index 0) or image_height (index 1); a write
// restarts the image and is made only while the block is idle.
// Throughput: one sample per cycle while out_o is not stalled. The line
// buffer is read when a sample is accepted and written when it leaves the
// compute register, with the last write forwarded, so a read-modify-write
// completes each cycle; a result then passes through the output register.
// Reset: registers return to 2x2, positions to the image origin; the line
// buffer needs no clearing since row 0 writes every entry it reads later.
// Stall: with out_o stalled, one word waits in the output register and one
// sample in the compute register; in_i drops ready only when both are full.
// ----------------------------------------------------------------------------
module max_pool_3x3_stride2 #(
  parameter int unsigned MaxWidth = mp3s2_pkg::MAX_WIDTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  mp3s2_in_if.sink    in_i,
  mp3s2_out_if.source out_o,
  mp3s2_cfg_if.sink   cfg_i
);
  import mp3s2_pkg::*;

  localparam int unsigned Depth = MaxWidth / 2;
  localparam int unsigned AW    = (MaxWidth > 2) ? $clog2(MaxWidth) - 1 : 1;

  logic          accept, cfg_we, busy, in_ready;
  pos_t          pos;
  logic [AW-1:0] col_idx;
  logic [31:0]   rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;

  assign cfg_i.ready = !busy;
  assign cfg_we      = cfg_i.valid && !busy;
  assign in_i.ready  = in_ready;
  assign accept      = in_i.valid && in_ready;

  mp3s2_seq #(.MaxWidth(MaxWidth)) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .accept_i   (accept),
    .pos_o      (pos),
    .col_idx_o  (col_idx)
  );

  mp3s2_lbuf #(.Depth(Depth), .AW(AW)) u_lbuf (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_idx),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  mp3s2_core #(.AW(AW)) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clr_i        (cfg_we),
    .accept_i     (accept),
    .sample_i     (in_i.sample),
    .pos_i        (pos),
    .col_idx_i    (col_idx),
    .rd_data_i    (rd_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .busy_o       (busy),
    .in_ready_o   (in_ready),
    .out_valid_o  (out_o.valid),
    .out_pooled_o (out_o.pooled),
    .out_last_o   (out_o.last),
    .out_ready_i  (out_o.ready)
  );

endmodule

[test/tb_max_pool_3x3_stride2.sv]
// ----------------------------------------------------------------------------
// tb_max_pool_3x3_stride2
// Streams float32 images through the pooler under random source and sink
// gaps, predicts each pooled word and its last flag, and checks them in order.
// ----------------------------------------------------------------------------
module tb_max_pool_3x3_stride2;
  import mp3s2_pkg::*;

  typedef struct packed {
    logic [31:0] pooled;
    logic        last;
  } pool_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mp3s2_in_if  in_ch ();
  mp3s2_out_if out_ch ();
  mp3s2_cfg_if cfg_ch ();

  max_pool_3x3_stride2 i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // prediction state
  logic [12:0] cur_width;
  logic [15:0] cur_height;
  int unsigned col_pos;
  int unsigned row_pos;
  logic [31:0] hmax;
  logic [31:0] col_max [MAX_WIDTH/2];

  pool_word_t  pooled_q[$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          stall_long;
  bit          no_gaps;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // IEEE single a > b without NaN handling ambiguity
  function automatic bit float_gt(logic [31:0] a, logic [31:0] b);
    bit a_nan;
    bit b_nan;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 0);
    if (a_nan || b_nan) return 1'b0;
    if (a[30:0] == 0 && b[30:0] == 0) return 1'b0;
    if (a[31] != b[31]) return b[31];
    if (!a[31]) return a[30:0] > b[30:0];
    return a[30:0] < b[30:0];
  endfunction

  function automatic logic [31:0] larger(logic [31:0] older, logic [31:0] newer);
    return float_gt(newer, older) ? newer : older;
  endfunction

  task automatic predict_pool(logic [31:0] s);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    bit          hdone;
    logic [31:0] hval;
    logic [31:0] v;
    w = (cur_width < 2) ? 2 : ((cur_width > MAX_WIDTH) ? MAX_WIDTH : cur_width);
    h = (cur_height < 2) ? 2 : cur_height;
    hdone = 0;
    hval = '0;
    c = 0;
    if (col_pos == 0) begin
      hmax = s;
    end else if (col_pos[0]) begin
      hmax = larger(hmax, s);
      if (col_pos == w - 1) begin
        hdone = 1;
        hval = hmax;
        c = (col_pos - 1) >> 1;
      end
    end else begin
      hval = larger(hmax, s);
      hdone = 1;
      c = (col_pos - 2) >> 1;
      hmax = s;
    end
    if (hdone && c < MAX_WIDTH/2) begin
      if (row_pos == 0) begin
        col_max[c] = hval;
      end else if (row_pos[0]) begin
        v = larger(col_max[c], hval);
        col_max[c] = v;
        if (row_pos == h - 1) pooled_q.push_back('{v, col_pos == w - 1});
      end else begin
        v = larger(col_max[c], hval);
        col_max[c] = hval;
        pooled_q.push_back('{v, (col_pos == w - 1) && (row_pos == h - 1)});
      end
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  // valid stays up between back-to-back words; drain drops it
  task automatic send_sample(logic [31:0] s);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_pool(s);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pooled_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == RegImageWidth) cur_width = val[12:0];
    else cur_height = val;
    col_pos = 0;
    row_pos = 0;
    hmax = '0;
  endtask

  task automatic set_shape(int unsigned w, int unsigned h);
    write_reg(RegImageWidth, 16'(w));
    write_reg(RegImageHeight, 16'(h));
  endtask

  function automatic logic [31:0] random_float();
    unique case ($urandom_range(0, 7))
      0: return {1'($urandom_range(0, 1)), 31'd0};
      1: return {1'($urandom_range(0, 1)), 8'hFF, 23'd0};
      2: return {1'($urandom_range(0, 1)), 8'hFF, 23'($urandom_range(1, 8))};
      3: return {1'($urandom_range(0, 1)), 8'd127, 23'($urandom_range(0, 3))};
      default: return $urandom();
    endcase
  endfunction

  task automatic send_image(int unsigned n);
    repeat (n) send_sample(random_float());
  endtask

  // checks every accepted output word against the prediction queue
  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) begin
      if (pooled_q.size() == 0) begin
        report_mismatch("unexpected word", out_ch.pooled, 32'd0);
      end else begin
        pool_word_t e;
        e = pooled_q.pop_front();
        if (out_ch.pooled !== e.pooled) report_mismatch("pooled", out_ch.pooled, e.pooled);
        if (out_ch.last !== e.last) begin
          report_mismatch("last", 32'(out_ch.last), 32'(e.last));
        end
      end
    end
  end

  // out-side sink with random stalls and one long hold-off
  initial begin
    int unsigned wait_n;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (stall_long) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        stall_long = 0;
      end
      wait_n = no_gaps ? 0 : $urandom_range(0, 11);
      if (wait_n != 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 5000) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_directed;
    set_shape(3, 3);
    send_sample(32'h3F800000);
    send_sample(32'h80000000);
    send_sample(32'h00000000);
    send_sample(32'hFF800000);
    send_sample(32'h7F800000);
    send_sample(32'h7FC00000);
    send_sample(32'hFFFFFFFF);
    send_sample(32'h7F7FFFFF);
    send_sample(32'hFF7FFFFF);
    set_shape(2, 2);
    send_image(4);
    set_shape(1, 0);           // acts as 2x2
    send_image(4);
    set_shape(5, 4);
    send_image(12);            // restart mid-image by the next write
  endtask

  task automatic test_random_shapes;
    int unsigned w;
    int unsigned h;
    repeat (4) begin
      w = $urandom_range(2, 9);
      h = $urandom_range(2, 7);
      set_shape(w, h);
      send_image(w * h * $urandom_range(1, 2));
    end
  endtask

  task automatic test_back_pressure;
    set_shape(6, 5);
    no_gaps = 1;
    stall_long = 1;
    send_image(60);
    no_gaps = 0;
  endtask

  task automatic test_wide_extremes;
    set_shape(4096, 2);
    send_image(4096 * 2 / 64);  // partial row, restart on next write
    set_shape(8191, 3);          // clamps to max width
    send_image(100);
    set_shape(16'hFFFF, 16'hFFFF);
    send_image(40);
    set_shape(3, 16'hFFFF);
    send_image(30);
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = RegImageWidth;
    cfg_ch.data  = '0;
    mismatches   = 0;
    stall_long   = 0;
    no_gaps      = 0;
    cur_width    = 2;
    cur_height   = 2;
    col_pos      = 0;
    row_pos      = 0;
    hmax         = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_shapes();
    test_back_pressure();
    test_wide_extremes();
    test_random_shapes();
    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pooled_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
